/* rtl/core/vgcq_pkg.sv */
package vgcq_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIndexW = 8;
  localparam logic [CfgIndexW-1:0] CfgStabilityTime = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgNotifyEnable  = 8'd1;

  localparam logic [31:0] StabilityTimeReset = 32'd500_000;

  typedef enum logic [1:0] {
    OpFrame = 2'd0,
    OpAck   = 2'd1,
    OpAbort = 2'd2,
    OpSpare = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PollOk          = 2'd0,
    PollTimeout     = 2'd1,
    PollUnavailable = 2'd2,
    PollFailed      = 2'd3
  } poll_e;

  typedef enum logic [3:0] {
    StAccepted    = 4'd0,
    StTimeout     = 4'd1,
    StLost        = 4'd2,
    StFailed      = 4'd3,
    StInvalid     = 4'd4,
    StStale       = 4'd5,
    StAdapterChg  = 4'd6,
    StPending     = 4'd7,
    StAborted     = 4'd8,
    StAckOk       = 4'd9,
    StAckBadArg   = 4'd10,
    StAckBadState = 4'd11
  } status_e;

  // One request as captured at the input
  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  poll_status;
    logic        source_match;
    logic        frame_valid;
    logic [31:0] generation;
    logic [63:0] adapter_id;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  format_code;
    logic [31:0] sequence_number;
    logic [47:0] timestamp_us;
    logic        push_ok;
  } item_t;

  // One answer
  typedef struct packed {
    logic [3:0]  status;
    logic        forward_frame;
    logic        geometry_event;
    logic [15:0] event_width;
    logic [15:0] event_height;
    logic [7:0]  event_format;
  } result_t;

  // Live configuration
  typedef struct packed {
    logic [31:0] stability_time_us;
    logic        notify_enable;
  } cfg_t;

endpackage

/* rtl/core/vgcq_in_stage.sv */
module vgcq_in_stage import vgcq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // Stage can take an item when empty or when its item moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

/* rtl/core/vgcq_core.sv */
module vgcq_core import vgcq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    fire_i,
  output result_t result_o
);

  // Tracking state
  logic        aborted_q, aborted_d;
  logic        has_cur_q, has_cur_d;
  logic [31:0] cur_gen_q, cur_gen_d;
  logic [63:0] cur_adapter_q, cur_adapter_d;
  logic [15:0] cur_w_q, cur_w_d;
  logic [15:0] cur_h_q, cur_h_d;
  logic [7:0]  cur_fmt_q, cur_fmt_d;
  logic        has_cand_q, has_cand_d;
  logic [31:0] cand_gen_q, cand_gen_d;
  logic [15:0] cand_w_q, cand_w_d;
  logic [15:0] cand_h_q, cand_h_d;
  logic [7:0]  cand_fmt_q, cand_fmt_d;
  logic [31:0] cand_seq_q, cand_seq_d;
  logic [47:0] cand_first_q, cand_first_d;
  logic [47:0] cand_last_q, cand_last_d;
  logic        raised_q, raised_d;

  logic        bad_frame;
  logic        same_cur;
  logic        same_cand;
  logic        ack_size_bad;
  logic [47:0] elapsed;
  logic        stable;
  result_t     res;

  // Shared comparisons
  assign bad_frame = !item_i.source_match || !item_i.frame_valid ||
                     (item_i.generation == '0) || (item_i.sequence_number == '0) ||
                     (item_i.image_width == '0) || (item_i.image_height == '0);
  assign same_cur  = (item_i.image_width == cur_w_q) &&
                     (item_i.image_height == cur_h_q) &&
                     (item_i.format_code == cur_fmt_q);
  assign same_cand = (item_i.image_width == cand_w_q) &&
                     (item_i.image_height == cand_h_q) &&
                     (item_i.format_code == cand_fmt_q);
  assign ack_size_bad = (item_i.image_width == '0) || (item_i.image_height == '0);
  // Candidate time never runs backwards, so this does not wrap
  assign elapsed   = item_i.timestamp_us - cand_first_q;
  assign stable    = elapsed >= {16'd0, cfg_i.stability_time_us};

  // Decision and next state
  always_comb begin
    aborted_d     = aborted_q;
    has_cur_d     = has_cur_q;
    cur_gen_d     = cur_gen_q;
    cur_adapter_d = cur_adapter_q;
    cur_w_d       = cur_w_q;
    cur_h_d       = cur_h_q;
    cur_fmt_d     = cur_fmt_q;
    has_cand_d    = has_cand_q;
    cand_gen_d    = cand_gen_q;
    cand_w_d      = cand_w_q;
    cand_h_d      = cand_h_q;
    cand_fmt_d    = cand_fmt_q;
    cand_seq_d    = cand_seq_q;
    cand_first_d  = cand_first_q;
    cand_last_d   = cand_last_q;
    raised_d      = raised_q;
    res           = '0;
    res.status    = StInvalid;

    unique case (op_e'(item_i.op))
      OpFrame: begin
        if (aborted_q) begin
          res.status = StAborted;
        end else if (item_i.poll_status == PollTimeout) begin
          res.status = StTimeout;
        end else if (item_i.poll_status == PollUnavailable) begin
          res.status = StLost;
        end else if (item_i.poll_status == PollFailed) begin
          res.status = StFailed;
        end else if (bad_frame) begin
          res.status = StInvalid;
        end else if (has_cur_q && (item_i.generation < cur_gen_q)) begin
          res.status = StStale;
        end else if (has_cur_q && (item_i.adapter_id != cur_adapter_q)) begin
          res.status = StAdapterChg;
        end else if (has_cur_q && (item_i.generation == cur_gen_q) && !same_cur) begin
          res.status = StInvalid;
        end else if (raised_q) begin
          res.status = StPending;
        end else if (has_cur_q && !same_cur) begin
          // New geometry: open or extend the candidate
          if (has_cand_q && (item_i.generation < cand_gen_q)) begin
            res.status = StStale;
          end else if (has_cand_q && (item_i.generation == cand_gen_q) && !same_cand) begin
            res.status = StInvalid;
          end else if (!has_cand_q || (item_i.generation != cand_gen_q) || !same_cand) begin
            res.status   = StPending;
            has_cand_d   = 1'b1;
            cand_gen_d   = item_i.generation;
            cand_w_d     = item_i.image_width;
            cand_h_d     = item_i.image_height;
            cand_fmt_d   = item_i.format_code;
            cand_seq_d   = item_i.sequence_number;
            cand_first_d = item_i.timestamp_us;
            cand_last_d  = item_i.timestamp_us;
          end else if ((item_i.sequence_number <= cand_seq_q) ||
                       (item_i.timestamp_us < cand_last_q)) begin
            res.status = StStale;
          end else begin
            res.status  = StPending;
            cand_seq_d  = item_i.sequence_number;
            cand_last_d = item_i.timestamp_us;
            if (stable) begin
              raised_d = 1'b1;
              if (cfg_i.notify_enable) begin
                res.geometry_event = 1'b1;
                res.event_width    = cand_w_q;
                res.event_height   = cand_h_q;
                res.event_format   = cand_fmt_q;
              end
            end
          end
        end else begin
          // Matching geometry or no current one: drop any candidate, forward if push_ok
          has_cand_d   = 1'b0;
          cand_gen_d   = '0;
          cand_w_d     = '0;
          cand_h_d     = '0;
          cand_fmt_d   = '0;
          cand_seq_d   = '0;
          cand_first_d = '0;
          cand_last_d  = '0;
          raised_d     = 1'b0;
          if (item_i.push_ok) begin
            res.status        = StAccepted;
            res.forward_frame = 1'b1;
            has_cur_d         = 1'b1;
            cur_gen_d         = item_i.generation;
            cur_adapter_d     = item_i.adapter_id;
            cur_w_d           = item_i.image_width;
            cur_h_d           = item_i.image_height;
            cur_fmt_d         = item_i.format_code;
          end else begin
            res.status = StInvalid;
          end
        end
      end
      OpAck: begin
        if (ack_size_bad) begin
          res.status = StAckBadArg;
        end else if (aborted_q || !raised_q || !has_cand_q) begin
          res.status = StAckBadState;
        end else if ((item_i.image_width != cand_w_q) ||
                     (item_i.image_height != cand_h_q)) begin
          res.status = StAckBadArg;
        end else begin
          res.status   = StAckOk;
          has_cur_d    = 1'b1;
          cur_gen_d    = cand_gen_q;
          cur_w_d      = cand_w_q;
          cur_h_d      = cand_h_q;
          cur_fmt_d    = cand_fmt_q;
          has_cand_d   = 1'b0;
          cand_gen_d   = '0;
          cand_w_d     = '0;
          cand_h_d     = '0;
          cand_fmt_d   = '0;
          cand_seq_d   = '0;
          cand_first_d = '0;
          cand_last_d  = '0;
          raised_d     = 1'b0;
        end
      end
      OpAbort: begin
        aborted_d  = 1'b1;
        res.status = StAborted;
      end
      default: begin
        res.status = StInvalid;
      end
    endcase
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aborted_q     <= 1'b0;
      has_cur_q     <= 1'b0;
      cur_gen_q     <= '0;
      cur_adapter_q <= '0;
      cur_w_q       <= '0;
      cur_h_q       <= '0;
      cur_fmt_q     <= '0;
      has_cand_q    <= 1'b0;
      cand_gen_q    <= '0;
      cand_w_q      <= '0;
      cand_h_q      <= '0;
      cand_fmt_q    <= '0;
      cand_seq_q    <= '0;
      cand_first_q  <= '0;
      cand_last_q   <= '0;
      raised_q      <= 1'b0;
    end else if (fire_i) begin
      aborted_q     <= aborted_d;
      has_cur_q     <= has_cur_d;
      cur_gen_q     <= cur_gen_d;
      cur_adapter_q <= cur_adapter_d;
      cur_w_q       <= cur_w_d;
      cur_h_q       <= cur_h_d;
      cur_fmt_q     <= cur_fmt_d;
      has_cand_q    <= has_cand_d;
      cand_gen_q    <= cand_gen_d;
      cand_w_q      <= cand_w_d;
      cand_h_q      <= cand_h_d;
      cand_fmt_q    <= cand_fmt_d;
      cand_seq_q    <= cand_seq_d;
      cand_first_q  <= cand_first_d;
      cand_last_q   <= cand_last_d;
      raised_q      <= raised_d;
    end
  end

endmodule

/* rtl/core/vgcq_out_stage.sv */
module vgcq_out_stage import vgcq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_valid_i,
  input  result_t load_result_i,
  output logic    load_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  // Register can take a new result when empty or being drained
  assign load_ready_o = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign result_o     = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && load_ready_o) begin
      result_q <= load_result_i;
    end
  end

endmodule

/* rtl/core/video_geometry_change_qualifier.sv */
// Request path: input register, then result register; the decision and
// state update sit between the two.
// Throughput: one request per cycle while results are taken; state is
// updated as each result is loaded, so the next request sees it at once.
// Reset (rst_ni, asynchronous, active low) clears all tracking state and
// restores stability_time_us to 500000 and notify_enable to 1.
module video_geometry_change_qualifier import vgcq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  // requests
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [1:0]           poll_status_i,
  input  logic                 source_match_i,
  input  logic                 frame_valid_i,
  input  logic [31:0]          generation_i,
  input  logic [63:0]          adapter_id_i,
  input  logic [15:0]          image_width_i,
  input  logic [15:0]          image_height_i,
  input  logic [7:0]           format_code_i,
  input  logic [31:0]          sequence_number_i,
  input  logic [47:0]          timestamp_us_i,
  input  logic                 push_ok_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           status_o,
  output logic                 forward_frame_o,
  output logic                 geometry_event_o,
  output logic [15:0]          event_width_o,
  output logic [15:0]          event_height_o,
  output logic [7:0]           event_format_o
);

  cfg_t    cfg_q;
  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    load_ready;
  logic    fire;
  result_t core_result;
  result_t out_result;

  // Configuration registers; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stability_time_us <= StabilityTimeReset;
      cfg_q.notify_enable     <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgStabilityTime: cfg_q.stability_time_us <= cfg_data_i;
        CfgNotifyEnable:  cfg_q.notify_enable     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Request bundle
  assign in_item.op              = op_i;
  assign in_item.poll_status     = poll_status_i;
  assign in_item.source_match    = source_match_i;
  assign in_item.frame_valid     = frame_valid_i;
  assign in_item.generation      = generation_i;
  assign in_item.adapter_id      = adapter_id_i;
  assign in_item.image_width     = image_width_i;
  assign in_item.image_height    = image_height_i;
  assign in_item.format_code     = format_code_i;
  assign in_item.sequence_number = sequence_number_i;
  assign in_item.timestamp_us    = timestamp_us_i;
  assign in_item.push_ok         = push_ok_i;

  // A request is processed when the result register can take its answer
  assign fire = stage_valid && load_ready;

  vgcq_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .advance_i  (load_ready),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  vgcq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (stage_item),
    .fire_i   (fire),
    .result_o (core_result)
  );

  vgcq_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_valid_i  (stage_valid),
    .load_result_i (core_result),
    .load_ready_o  (load_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_o      (out_result)
  );

  assign status_o         = out_result.status;
  assign forward_frame_o  = out_result.forward_frame;
  assign geometry_event_o = out_result.geometry_event;
  assign event_width_o    = out_result.event_width;
  assign event_height_o   = out_result.event_height;
  assign event_format_o   = out_result.event_format;

endmodule
